>>> rtl/core/fbpa_pkg.sv
// Shared types, codes and constants for the fixed block pool allocator.
// Used by fbpa_div and fixed_block_pool_allocator; depends on nothing.
package fbpa_pkg;

    // Default pool depth in slots
    localparam int MAX_SLOTS_DEF = 1024;

    // Field widths
    localparam int ADDR_W    = 32;
    localparam int BLOCK_W   = 17;
    localparam int ALIGN_W   = 8;
    localparam int FUNC_W    = 2;
    localparam int LIVE_W    = 11;
    localparam int CFG_IDX_W = 2;

    // Divider widths
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 17;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN = 2'd3;

    // Request payload
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] free_address;
    } t_in_req;

    // Response payload
    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        logic              pool_empty;
        logic [ADDR_W-1:0] bytes_in_use;
        logic [LIVE_W-1:0] blocks_in_use;
    } t_out_rsp;

    // Divider control toward the divider
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    // Divider status back to the controller
    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } t_div_rsp;

endpackage

>>> rtl/core/fbpa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/fbpa_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on fbpa_pkg for widths and the request/status structs.
module fbpa_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fbpa_pkg::t_div_req i_req,
    output fbpa_pkg::t_div_rsp o_rsp
);
    import fbpa_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0]    w_shift;
    logic [DIVISOR_W+1:0]  w_diff;
    logic                  w_ge;

    // Trial subtract of the divisor from the shifted partial remainder
    assign w_shift = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_diff  = {1'b0, w_shift} - (DIVISOR_W+2)'(r_div);
    assign w_ge    = ~w_diff[DIVISOR_W+1];

    // Control: start, count steps, pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then shift in one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

>>> rtl/core/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator: free list of slot links in a RAM.
// Depends on fbpa_pkg, fbpa_ram and fbpa_div.
//
// Usage:
//   Requests arrive on i_in_valid/o_in_ready with i_in_req (func and
//   free_address); one response per request leaves on o_out_valid/i_out_ready
//   with o_out_rsp (block address, empty flag, byte and block counters).
//   Configuration is written through i_cfg_we/i_cfg_index/i_cfg_wdata while
//   no request is in flight; clear picks up the new layout.
// Steps per request:
//   allocate reads the link RAM, then adds the address; allocate on an empty
//   pool, unused codes and a free or clear that skips the divider go straight
//   to the response; free runs the 32-step serial divider that turns the offset
//   into a slot number; clear runs the divider and then the link RAM write port
//   that fills one link a cycle.
// One request is worked on at a time; the next is taken as soon as the
// controller is idle, even while the previous response still waits.
// Reset empties the free list and zeros the counters; the link RAM is not
// cleared, clear writes every link it uses. A stalled receiver holds the
// response register; a finished result then waits until it drains.
module fixed_block_pool_allocator #(
    parameter int MAX_SLOTS = fbpa_pkg::MAX_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]    i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  fbpa_pkg::t_in_req              i_in_req,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output fbpa_pkg::t_out_rsp             o_out_rsp
);
    import fbpa_pkg::*;

    localparam int SLOT_W  = $clog2(MAX_SLOTS + 1);
    localparam int RAM_AW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int PROD_W  = SLOT_W + BLOCK_W;
    localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(MAX_SLOTS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ALLOC = 5'b00010,
        S_DIV   = 5'b00100,
        S_FILL  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // Configuration registers
    logic [ADDR_W-1:0]  r_base;
    logic [ADDR_W-1:0]  r_pool;
    logic [BLOCK_W-1:0] r_block;
    logic [ALIGN_W-1:0] r_align;

    // Allocator state
    t_state             r_state;
    logic [SLOT_W-1:0]  r_head;
    logic [ADDR_W-1:0]  r_used;
    logic [LIVE_W-1:0]  r_live;
    logic [ADDR_W-1:0]  r_start;
    logic               r_is_clear;
    logic [PROD_W-1:0]  r_prod;
    logic [SLOT_W-1:0]  r_count;
    logic [SLOT_W-1:0]  r_fill;
    logic [ADDR_W-1:0]  r_res_addr;
    logic               r_res_empty;
    logic               r_out_valid;
    t_out_rsp           r_out;

    // Combinational helpers
    logic               w_accept;
    logic [ALIGN_W-1:0] w_mask;
    logic [ALIGN_W-1:0] w_adj;
    logic [ADDR_W-1:0]  w_free_off;
    logic [ADDR_W-1:0]  w_pool_left;
    logic               w_clear_ok;
    logic               w_free_hit;
    logic [SLOT_W-1:0]  n_count;
    logic [SLOT_W-1:0]  n_fill;
    logic               w_fill_last;
    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;

    // Link RAM ports
    logic               w_ram_we;
    logic [RAM_AW-1:0]  w_ram_waddr;
    logic [SLOT_W-1:0]  w_ram_wdata;
    logic               w_ram_re;
    logic [SLOT_W-1:0]  w_ram_rdata;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid & o_in_ready;

    // Alignment of the first block
    assign w_mask      = (r_align == '0) ? '0 : r_align - 1'b1;
    assign w_adj       = (ALIGN_W'(0) - r_base[ALIGN_W-1:0]) & w_mask;
    assign w_pool_left = r_pool - ADDR_W'(w_adj);
    assign w_clear_ok  = (r_block != '0) && (r_pool >= ADDR_W'(w_adj));
    assign w_free_off  = i_in_req.free_address - r_start;

    // Divider operands: block offset on free, remaining bytes on clear
    assign w_div_req.start = w_accept &&
        (((i_in_req.func == FUNC_FREE) && (r_block != '0)) ||
         ((i_in_req.func == FUNC_CLEAR) && w_clear_ok));
    assign w_div_req.dividend = (i_in_req.func == FUNC_CLEAR) ? w_pool_left : w_free_off;
    assign w_div_req.divisor  = r_block;

    // Slot count from the quotient, capped at the pool depth
    assign n_count = (w_div_rsp.quotient >= DIVIDEND_W'(MAX_SLOTS)) ?
                     NULL_SLOT : w_div_rsp.quotient[SLOT_W-1:0];
    assign w_free_hit = (w_div_rsp.remainder == '0) &&
                        (w_div_rsp.quotient < DIVIDEND_W'(MAX_SLOTS));

    // Fill walk: link each slot to the next, the last to the null marker
    assign n_fill      = r_fill + 1'b1;
    assign w_fill_last = (n_fill == r_count);

    // Link RAM write: push on a valid free, one link a cycle during fill
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = r_fill[RAM_AW-1:0];
        w_ram_wdata = w_fill_last ? NULL_SLOT : n_fill;
        if (r_state == S_FILL) begin
            w_ram_we = 1'b1;
        end else if ((r_state == S_DIV) && w_div_rsp.done && !r_is_clear && w_free_hit) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = w_div_rsp.quotient[RAM_AW-1:0];
            w_ram_wdata = r_head;
        end
    end

    // Read the head link when an allocate is taken
    assign w_ram_re = w_accept && (i_in_req.func == FUNC_ALLOC);

    fbpa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_head[RAM_AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    fbpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_pool  <= '0;
            r_block <= BLOCK_W'(8);
            r_align <= ALIGN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE:  r_base  <= i_cfg_wdata;
                CFG_POOL:  r_pool  <= i_cfg_wdata;
                CFG_BLOCK: r_block <= i_cfg_wdata[BLOCK_W-1:0];
                CFG_ALIGN: r_align <= i_cfg_wdata[ALIGN_W-1:0];
            endcase
        end
    end

    // Slot address product, registered ahead of the base add
    always_ff @(posedge i_clk) begin
        if (w_ram_re) begin
            r_prod <= PROD_W'(r_head) * PROD_W'(r_block);
        end
    end

    // Controller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= NULL_SLOT;
            r_used      <= '0;
            r_live      <= '0;
            r_start     <= '0;
            r_is_clear  <= 1'b0;
            r_count     <= '0;
            r_fill      <= '0;
            r_res_addr  <= '0;
            r_res_empty <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the response once taken, unless a new one replaces it
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_addr  <= '0;
                        r_res_empty <= 1'b0;
                        r_is_clear  <= (i_in_req.func == FUNC_CLEAR);
                        r_state     <= S_DONE;
                        case (i_in_req.func)
                            FUNC_ALLOC: begin
                                if (r_head == NULL_SLOT) begin
                                    r_res_empty <= 1'b1;
                                end else begin
                                    r_state <= S_ALLOC;
                                end
                            end
                            FUNC_FREE: begin
                                if (r_block != '0) begin
                                    r_state <= S_DIV;
                                end
                            end
                            FUNC_CLEAR: begin
                                r_start <= r_base + ADDR_W'(w_adj);
                                if (w_clear_ok) begin
                                    r_state <= S_DIV;
                                end else begin
                                    r_head <= NULL_SLOT;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                // Pop the head: next link arrives from the RAM
                S_ALLOC: begin
                    r_head     <= w_ram_rdata;
                    r_res_addr <= r_start + ADDR_W'(r_prod);
                    r_used     <= r_used + ADDR_W'(r_block);
                    r_live     <= r_live + 1'b1;
                    r_state    <= S_DONE;
                end

                // Wait for the quotient, then push or start the fill
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        if (r_is_clear) begin
                            r_count <= n_count;
                            r_fill  <= '0;
                            if (n_count == '0) begin
                                r_head  <= NULL_SLOT;
                                r_state <= S_DONE;
                            end else begin
                                r_head  <= '0;
                                r_state <= S_FILL;
                            end
                        end else begin
                            if (w_free_hit) begin
                                r_head <= w_div_rsp.quotient[SLOT_W-1:0];
                                r_used <= r_used - ADDR_W'(r_block);
                                r_live <= r_live - 1'b1;
                            end
                            r_state <= S_DONE;
                        end
                    end
                end

                // Advance through the slots, one link a cycle
                S_FILL: begin
                    r_fill <= n_fill;
                    if (w_fill_last) begin
                        r_state <= S_DONE;
                    end
                end

                // Hold the result until the response register frees up
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Response payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && (!r_out_valid || i_out_ready)) begin
            r_out.block_address <= r_res_addr;
            r_out.pool_empty    <= r_res_empty;
            r_out.bytes_in_use  <= r_used;
            r_out.blocks_in_use <= r_live;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

`ifndef NO_ASSERTIONS
    // The head is a real slot or the null marker
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= NULL_SLOT)
        else $error("free list head beyond null marker");

    // Link RAM is written only on a free push or during the fill walk
    a_ram_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == S_DIV || r_state == S_FILL))
        else $error("link RAM written outside free or fill");

    // Fill pointer stays inside the counted slots
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_fill < r_count))
        else $error("fill walk past slot count");

    // A new response only follows a finished request
    a_resp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> $past(r_state == S_DONE))
        else $error("response raised without finished request");
`endif

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the fixed block pool allocator: a tracker class
// predicts each response from a copy of the free list, counters and layout.
// Depends on fbpa_pkg and fixed_block_pool_allocator.
module testbench;
    import fbpa_pkg::*;

    localparam int              SLOTS      = MAX_SLOTS_DEF;
    localparam logic [10:0]     NO_SLOT    = 11'(SLOTS);
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    // Shadow of the allocator: layout registers, free list and counters
    class pool_tracker;
        logic [31:0] base_addr;
        logic [31:0] pool_size;
        logic [16:0] block_size;
        logic [7:0]  align;
        logic [31:0] aligned_start;
        logic [31:0] used_bytes;
        logic [10:0] live_blocks;
        logic [10:0] head_slot;
        logic [10:0] next_link [SLOTS];
        t_out_rsp    rsp_due_q[$];
        logic [31:0] granted[$];
        int          errors;

        function new();
            base_addr     = '0;
            pool_size     = '0;
            block_size    = 17'd8;
            align         = 8'd1;
            aligned_start = '0;
            used_bytes    = '0;
            live_blocks   = '0;
            head_slot     = NO_SLOT;
            errors        = 0;
        endfunction

        // Mask the write data to the register width
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                CFG_BASE:  base_addr = value;
                CFG_POOL:  pool_size = value;
                CFG_BLOCK: block_size = value[16:0];
                CFG_ALIGN: align = value[7:0];
                default: ;
            endcase
        endfunction

        // Align the start, size the pool and chain all slots in order
        function void rebuild_list();
            logic [31:0] mask;
            logic [31:0] adj;
            logic [31:0] q;
            int unsigned count;
            mask = (align == 8'd0) ? 32'd0 : {24'd0, align - 8'd1};
            adj = (32'd0 - base_addr) & mask;
            aligned_start = base_addr + adj;
            count = 0;
            if (block_size != 17'd0 && pool_size >= adj) begin
                q = (pool_size - adj) / {15'd0, block_size};
                count = (q > SLOTS) ? SLOTS : q;
            end
            granted.delete();
            if (count == 0) begin
                head_slot = NO_SLOT;
                return;
            end
            for (int unsigned i = 0; i + 1 < count; i++) begin
                next_link[i] = 11'(i + 1);
            end
            next_link[count - 1] = NO_SLOT;
            head_slot = '0;
        endfunction

        // Push the slot back, or drop an address that maps to no slot
        function void release_slot(logic [31:0] addr);
            logic [31:0] off;
            logic [31:0] slot;
            if (block_size == 17'd0) return;
            off = addr - aligned_start;
            if (off % {15'd0, block_size} != 32'd0) return;
            slot = off / {15'd0, block_size};
            if (slot >= SLOTS) return;
            next_link[slot] = head_slot;
            head_slot = slot[10:0];
            used_bytes = used_bytes - {15'd0, block_size};
            live_blocks = live_blocks - 11'd1;
        endfunction

        // Predict the response of an accepted request and queue it
        function void take_request(t_in_req req);
            t_out_rsp rsp;
            rsp = '0;
            case (req.func)
                FUNC_ALLOC: begin
                    if (head_slot >= NO_SLOT) begin
                        rsp.pool_empty = 1'b1;
                    end else begin
                        rsp.block_address = aligned_start
                                          + 32'(head_slot) * {15'd0, block_size};
                        granted.push_back(rsp.block_address);
                        head_slot = next_link[head_slot];
                        used_bytes = used_bytes + {15'd0, block_size};
                        live_blocks = live_blocks + 11'd1;
                    end
                end
                FUNC_FREE:  release_slot(req.free_address);
                FUNC_CLEAR: rebuild_list();
                default: ;
            endcase
            rsp.bytes_in_use = used_bytes;
            rsp.blocks_in_use = live_blocks;
            rsp_due_q.push_back(rsp);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compare a response with the oldest prediction
        task check_response(t_out_rsp got);
            t_out_rsp want;
            if (rsp_due_q.size() == 0) begin
                report($sformatf("unexpected response %h", got));
                return;
            end
            want = rsp_due_q.pop_front();
            if (got.block_address !== want.block_address)
                report($sformatf("block_address %h, want %h",
                                 got.block_address, want.block_address));
            if (got.pool_empty !== want.pool_empty)
                report($sformatf("pool_empty %b, want %b", got.pool_empty, want.pool_empty));
            if (got.bytes_in_use !== want.bytes_in_use)
                report($sformatf("bytes_in_use %h, want %h",
                                 got.bytes_in_use, want.bytes_in_use));
            if (got.blocks_in_use !== want.blocks_in_use)
                report($sformatf("blocks_in_use %0d, want %0d",
                                 got.blocks_in_use, want.blocks_in_use));
        endtask
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ADDR_W-1:0]    i_cfg_wdata = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_req              i_in_req    = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_rsp             o_out_rsp;

    pool_tracker tracker = new();
    bit          burst_mode = 1'b0;
    int unsigned ready_hold = 0;

    fixed_block_pool_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    always #5 i_clk = ~i_clk;

    // Check each accepted response, then hold ready low for a random stall outside burst mode
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.check_response(o_out_rsp);
            ready_hold = burst_mode ? 0 : $urandom_range(0, 9);
        end
        if (ready_hold > 0) begin
            ready_hold--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Offer one request after a random gap (none in burst mode) and hold it until accepted
    task automatic send_request(input logic [FUNC_W-1:0] func, input logic [31:0] addr);
        int unsigned gap;
        t_in_req     req;
        gap = burst_mode ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.func = func;
        req.free_address = addr;
        i_in_valid <= 1'b1;
        i_in_req <= req;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.take_request(req);
    endtask

    // Stop sending and wait until every predicted response has come back
    task automatic drain_responses();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.rsp_due_q.size() > 0) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        tracker.set_reg(idx, value);
    endtask

    // Write all four layout registers back to back; block must be idle
    task automatic write_layout(input logic [31:0] base, input logic [31:0] pool,
                                input logic [31:0] blk, input logic [31:0] aln);
        put_reg(CFG_BASE, base);
        put_reg(CFG_POOL, pool);
        put_reg(CFG_BLOCK, blk);
        put_reg(CFG_ALIGN, aln);
        i_cfg_we <= 1'b0;
    endtask

    // Rebuild the list, then mix allocate, free, clear and spare requests
    task automatic run_phase(input int unsigned items);
        int unsigned      pick;
        int unsigned      idx;
        logic [31:0]      addr;
        logic [FUNC_W-1:0] func;
        send_request(FUNC_CLEAR, $urandom);
        repeat (items) begin
            if ($urandom_range(0, 29) == 0) burst_mode = !burst_mode;
            if ($urandom_range(0, 49) == 0) drain_responses();
            addr = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                func = FUNC_ALLOC;
            end else if (pick < 82) begin
                func = FUNC_FREE;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        // return a block handed out earlier, sometimes keep it for a
                        // later double free
                        if (tracker.granted.size() > 0) begin
                            idx = $urandom_range(0, tracker.granted.size() - 1);
                            addr = tracker.granted[idx];
                            if ($urandom_range(0, 4) != 0) tracker.granted.delete(idx);
                        end
                    end
                    6: addr = tracker.aligned_start
                            + $urandom_range(0, 1100) * {15'd0, tracker.block_size};
                    7: ;
                    default: begin
                        // misaligned address inside a block
                        if (tracker.granted.size() > 0)
                            addr = tracker.granted[$urandom_range(0,
                                                   tracker.granted.size() - 1)]
                                 + $urandom_range(1, tracker.block_size - 1);
                    end
                endcase
            end else if (pick < 88) begin
                func = FUNC_CLEAR;
            end else if (pick < 94) begin
                func = FUNC_SPARE;
            end else begin
                func = FUNC_ALLOC;
            end
            send_request(func, addr);
        end
    endtask

    initial begin
        logic [31:0] base;
        logic [31:0] pool;
        logic [16:0] blk;
        logic [7:0]  aln;
        int unsigned slots;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset layout: empty list, free into an unbuilt pool, counter wrap
        send_request(FUNC_ALLOC, 32'h0);
        send_request(FUNC_SPARE, 32'h0);
        send_request(FUNC_FREE, 32'h0000_0008);
        send_request(FUNC_ALLOC, 32'h0);
        send_request(FUNC_CLEAR, 32'h0);
        send_request(FUNC_ALLOC, 32'h0);

        // Unaligned base, ten slots of 24 bytes starting at 0x1010
        drain_responses();
        write_layout(32'h0000_1003, 32'h0000_0100, 32'd24, 32'd16);
        send_request(FUNC_CLEAR, 32'h0);
        send_request(FUNC_ALLOC, 32'h0);
        send_request(FUNC_ALLOC, 32'h0);
        send_request(FUNC_ALLOC, 32'h0);
        send_request(FUNC_FREE, 32'h0000_1028);
        send_request(FUNC_FREE, 32'h0000_1029);
        send_request(FUNC_FREE, 32'h0000_7010);
        send_request(FUNC_FREE, 32'h0000_6FF8);
        send_request(FUNC_FREE, 32'h0000_1028);
        send_request(FUNC_ALLOC, 32'h0);
        send_request(FUNC_ALLOC, 32'h0);
        send_request(FUNC_ALLOC, 32'h0);
        send_request(FUNC_FREE, 32'h0000_0FF8);
        send_request(FUNC_SPARE, 32'hFFFF_FFFF);

        // Pool smaller than the alignment adjustment: no slots
        drain_responses();
        write_layout(32'h0000_0001, 32'd100, 32'd8, 32'd128);
        send_request(FUNC_CLEAR, 32'h0);
        send_request(FUNC_ALLOC, 32'h0);

        // Alignment that is not a power of two
        drain_responses();
        write_layout(32'h0000_0010, 32'h0000_0200, 32'd8, 32'h0000_0060);
        send_request(FUNC_CLEAR, 32'h0);
        send_request(FUNC_ALLOC, 32'h0);
        send_request(FUNC_ALLOC, 32'h0);

        // Random layouts: the first at the extremes, the second with a wide pool
        for (int p = 0; p < 8; p++) begin
            drain_responses();
            if (p == 0) begin
                write_layout(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0080);
            end else begin
                base = $urandom;
                case ($urandom_range(0, 3))
                    0: blk = $urandom_range(8, 64);
                    1: blk = $urandom_range(8, 65536);
                    2: blk = 17'h1_0000;
                    default: blk = 17'(8 * $urandom_range(1, 16));
                endcase
                if ($urandom_range(0, 3) == 0) aln = $urandom_range(1, 128);
                else aln = 8'(1 << $urandom_range(0, 7));
                slots = $urandom_range(0, 48);
                pool = (p == 1) ? $urandom
                                : slots * {15'd0, blk} + $urandom_range(0, 255);
                write_layout(base, pool, {15'($urandom), blk}, {24'($urandom), aln});
            end
            run_phase(88);
        end

        drain_responses();
        repeat (100) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #30_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
